### sv/order_statistic_multiset_top_macros.svh
// Assertion macros for the order-statistic multiset block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ORDER_STATISTIC_MULTISET_TOP_MACROS_SVH
`define ORDER_STATISTIC_MULTISET_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define OSM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define OSM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/osm_pkg.sv
// Package for the order-statistic multiset: payload structs, codes, defaults.
// No dependencies.
`default_nettype none
package osm_pkg;
	localparam int DefCapacity = 1024;
	localparam int DefKeyBits  = 32;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_ERASE  = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_RANK   = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] key_value;
		logic [15:0]        rank_wanted;
	} osm_req_t;

	typedef struct packed {
		logic signed [31:0] answer_key;
		logic [1:0]         status_code;
		logic [15:0]        element_total;
	} osm_rsp_t;
endpackage
`default_nettype wire

### sv/order_statistic_multiset_top.sv
// Order-statistic multiset: sorted key/count memories with a sequencer.
// Depends on osm_pkg and order_statistic_multiset_top_macros.svh.
//
// Usage: requests enter on req (valid/ready); one response per request
// leaves on rsp (valid/ready). Insert adds a copy of a key, erase removes
// one, query returns the k-th smallest copy.
// The block handles one request at a time. Each entry visited is read
// first, then compared on the registered data. The position search scans
// from the start; a new key or a removed entry then shifts the tail, each
// entry read and then written. A query sums counts from the start.
// Reset clears the counters; the count memory needs no clearing since only
// entries below the distinct count are ever read. After reset req_ready
// is high, since the sequencer starts idle.
// The response is held in an output register. While the receiver stalls,
// the next request is still taken and worked, then waits in the final state
// until the held response transfers; req_ready stays low meanwhile.
`default_nettype none
`include "order_statistic_multiset_top_macros.svh"
module order_statistic_multiset_top
	import osm_pkg::*;
#(
	parameter int DISTINCT_CAPACITY = DefCapacity,
	parameter int KEY_BITS = DefKeyBits
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire osm_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output osm_rsp_t      rsp
);
	localparam int AW = (DISTINCT_CAPACITY > 1) ? $clog2(DISTINCT_CAPACITY) : 1;
	localparam int UW = $clog2(DISTINCT_CAPACITY + 1);
	localparam int EW = KEY_BITS + 16;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1; // read entry at idx, wait
	localparam logic [2:0] S_CHECK = 3'd2; // examine read data
	localparam logic [2:0] S_SHRD  = 3'd3; // shift: read source
	localparam logic [2:0] S_SHWR  = 3'd4; // shift: write destination
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]          state_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [15:0]         left_q;
	logic [UW-1:0]       idx_q, pos_q, used_q;
	logic [15:0]         total_q;
	logic signed [31:0]  ans_q;
	logic [1:0]          st_q;
	osm_rsp_t            rsp_q;
	logic                busy_q;

	// memory: key in high bits, count in low 16
	logic [EW-1:0] mem [DISTINCT_CAPACITY];
	logic [EW-1:0] rd_q;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	logic [KEY_BITS-1:0] rd_key;
	logic [15:0]         rd_cnt;
	logic                rd_less, rd_eq;
	assign rd_key  = rd_q[EW-1:16];
	assign rd_cnt  = rd_q[15:0];
	assign rd_less = $signed(rd_key) < $signed(key_q);
	assign rd_eq   = rd_key == key_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = busy_q;
	assign rsp       = rsp_q;

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_q;
		unique case (state_q)
			S_SCAN: rd_en = 1'b1;
			S_SHRD: begin
				rd_en = 1'b1;
				// insert shifts up: read idx-1; erase shifts down: read idx+1
				rd_addr = (op_q == REQ_INSERT) ? AW'(idx_q - 1'b1) : AW'(idx_q + 1'b1);
			end
			S_SHWR: wr_en = 1'b1;
			S_CHECK: begin
				if (idx_q < used_q && op_q != REQ_QUERY && rd_eq && !(!rd_less && !rd_eq)) begin
					// existing key: bump or drop count in place
					wr_data = (op_q == REQ_INSERT) ? {rd_key, rd_cnt + 16'd1}
						: {rd_key, rd_cnt - 16'd1};
					wr_en = (op_q == REQ_INSERT) ? (rd_cnt != COUNT_MAX && total_q != COUNT_MAX)
						: (rd_cnt > 16'd1);
				end
			end
			default: ;
		endcase
		if (state_q == S_SHWR && idx_q == pos_q && op_q == REQ_INSERT)
			wr_data = {key_q, 16'd1};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			used_q  <= '0;
			total_q <= '0;
		end else begin
			if (busy_q && rsp_ready)
				busy_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req_valid && req_ready) begin
					op_q   <= req.req_type;
					key_q  <= KEY_BITS'(unsigned'(req.key_value));
					left_q <= req.rank_wanted;
					idx_q  <= '0;
					pos_q  <= '0;
					ans_q  <= '0;
					if (req.req_type == REQ_QUERY) begin
						if (req.rank_wanted == 16'd0 || req.rank_wanted > total_q) begin
							st_q    <= ST_RANK;
							state_q <= S_RESP;
						end else begin
							st_q    <= ST_OK;
							state_q <= S_SCAN;
						end
					end else if (req.req_type == REQ_UNUSED) begin
						st_q    <= ST_OK;
						state_q <= S_RESP;
					end else if (used_q == '0) begin
						if (req.req_type == REQ_ERASE) begin
							st_q    <= ST_ABSENT;
							state_q <= S_RESP;
						end else if (total_q == COUNT_MAX) begin
							st_q    <= ST_FULL;
							state_q <= S_RESP;
						end else begin
							st_q    <= ST_OK;
							state_q <= S_SHWR;
						end
					end else begin
						st_q    <= ST_OK;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: state_q <= S_CHECK;
				S_CHECK: begin
					if (op_q == REQ_QUERY) begin
						if (left_q <= rd_cnt) begin
							ans_q   <= 32'(signed'(rd_key));
							state_q <= S_RESP;
						end else begin
							left_q <= left_q - rd_cnt;
							idx_q  <= idx_q + 1'b1;
							state_q <= S_SCAN;
						end
					end else if (idx_q < used_q && rd_less) begin
						idx_q  <= idx_q + 1'b1;
						state_q <= (idx_q + 1'b1 < used_q) ? S_SCAN : S_CHECK;
					end else if (idx_q < used_q && rd_eq) begin
						pos_q <= idx_q;
						if (op_q == REQ_INSERT) begin
							if (rd_cnt == COUNT_MAX || total_q == COUNT_MAX)
								st_q <= ST_FULL;
							else
								total_q <= total_q + 16'd1;
							state_q <= S_RESP;
						end else begin
							total_q <= total_q - 16'd1;
							if (rd_cnt > 16'd1)
								state_q <= S_RESP;
							else if (idx_q + 1'b1 < used_q)
								state_q <= S_SHRD;
							else begin
								used_q  <= used_q - 1'b1;
								state_q <= S_RESP;
							end
						end
					end else begin
						// key absent; position is idx_q
						pos_q <= idx_q;
						if (op_q == REQ_ERASE) begin
							st_q    <= ST_ABSENT;
							state_q <= S_RESP;
						end else if (used_q == UW'(DISTINCT_CAPACITY) || total_q == COUNT_MAX) begin
							st_q    <= ST_FULL;
							state_q <= S_RESP;
						end else begin
							idx_q   <= used_q;
							state_q <= (used_q == idx_q) ? S_SHWR : S_SHRD;
						end
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (op_q == REQ_INSERT) begin
						if (idx_q == pos_q) begin
							used_q  <= used_q + 1'b1;
							total_q <= total_q + 16'd1;
							state_q <= S_RESP;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= (idx_q - 1'b1 == pos_q) ? S_SHWR : S_SHRD;
						end
					end else begin
						if (idx_q + UW'(2) >= used_q) begin
							used_q  <= used_q - 1'b1;
							state_q <= S_RESP;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SHRD;
						end
					end
				end
				// wait here until the output register is free
				S_RESP: if (!busy_q) begin
					rsp_q.answer_key    <= ans_q;
					rsp_q.status_code   <= st_q;
					rsp_q.element_total <= total_q;
					busy_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`OSM_ASSERT_IMP(a_used_bound, 1'b1, used_q <= UW'(DISTINCT_CAPACITY), "distinct count over capacity")
	`OSM_ASSERT_NXT(a_resp_wait, state_q == S_RESP && rsp_valid && !rsp_ready, state_q == S_RESP, "response slot overwritten")
	`OSM_ASSERT_IMP(a_total_vs_used, state_q == S_IDLE, 17'(total_q) >= 17'(used_q), "fewer copies than keys")
	`OSM_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")
endmodule
`default_nettype wire
